// ----- rtl/core/lws_pkg.sv -----
// ----------------------------------------------------------------------------
// lws_pkg
// Shared constants and types for the windowed latency statistics core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lws_pkg;

	localparam int unsigned CNT_W   = 32;
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned SUM_W   = 64;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;

	// Divider geometry: 64-bit dividend, 32-bit divisor, one quotient bit per step
	localparam int unsigned DIV_DVD_W  = SUM_W;
	localparam int unsigned DIV_DSR_W  = CNT_W;
	localparam int unsigned DIV_STEPS  = DIV_DVD_W;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [DIV_DSR_W-1:0] MS_DIVISOR = DIV_DSR_W'(1000);

	// Sum / 1000 by 16-bit digits, top digit first. Partial dividend is the
	// running remainder (below 1000) over one digit; the reciprocal with a
	// 38-bit shift is exact for any 26-bit partial dividend.
	localparam int unsigned MS_DIGIT_W     = 16;
	localparam int unsigned MS_DIGITS      = SUM_W / MS_DIGIT_W;
	localparam int unsigned MS_DIGIT_IDX_W = $clog2(MS_DIGITS);
	localparam int unsigned MS_REM_W       = 10;
	localparam int unsigned MS_PART_W      = MS_REM_W + MS_DIGIT_W;
	localparam int unsigned MS_RECIP_W     = 29;
	localparam int unsigned MS_PROD_W      = MS_PART_W + MS_RECIP_W;
	localparam int unsigned MS_RECIP_SHIFT = 38;
	localparam logic [MS_RECIP_W-1:0] MS_RECIP = MS_RECIP_W'(32'h1062_4DD3);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESH  = 2'd3;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] WINDOW_COUNT_RST = CFG_W'(1000);
	localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = CFG_W'(2 * 1000 * 1000);
	localparam logic [CFG_W-1:0] LOW_THRESH_RST   = CFG_W'(1000);
	localparam logic [CFG_W-1:0] HIGH_THRESH_RST  = CFG_W'(5000);

	typedef struct packed {
		logic              update;
		logic              clear;
		logic              note;
		logic [CNT_W-1:0]  elapsed;
	} lws_stat_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] note_count;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] maximum;
		logic [CNT_W-1:0] low_bin;
		logic [CNT_W-1:0] high_bin;
	} lws_stats_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lws_div_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/lws_divider.sv -----
// ----------------------------------------------------------------------------
// lws_divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lws_divider (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [lws_pkg::DIV_DVD_W-1:0]  dividend,
	input  wire logic [lws_pkg::DIV_DSR_W-1:0]  divisor,
	output lws_pkg::lws_div_status_t            status,
	output logic      [lws_pkg::DIV_DVD_W-1:0]  quotient
);
	import lws_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_DSR_W-1:0] rem_q;

	logic [DIV_DSR_W:0]   rem_shift;
	logic [DIV_DSR_W:0]   rem_diff;
	logic                 fits;

	// Quotient bits shift in at the bottom as dividend bits leave at the top
	assign rem_shift = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign fits      = rem_shift >= {1'b0, dsr_q};
	assign rem_diff  = rem_shift - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], fits};
			rem_q <= fits ? rem_diff[DIV_DSR_W-1:0] : rem_shift[DIV_DSR_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dvd_q;

endmodule

`default_nettype wire

// ----- rtl/core/lws_stats.sv -----
// ----------------------------------------------------------------------------
// lws_stats
// Window accumulators: sample and note-on counts, saturating sum, maximum
// and the two threshold bins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lws_stats (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lws_pkg::lws_stat_cmd_t     cmd,
	input  wire logic [lws_pkg::CFG_W-1:0]  low_threshold,
	input  wire logic [lws_pkg::CFG_W-1:0]  high_threshold,
	output lws_pkg::lws_stats_t             stats
);
	import lws_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] note_count_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] max_q;
	logic [CNT_W-1:0] low_bin_q;
	logic [CNT_W-1:0] high_bin_q;

	logic [SUM_W:0]   sum_ext;

	assign sum_ext = {1'b0, sum_q} + {(SUM_W - CNT_W + 1)'(0), cmd.elapsed};

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			note_count_q <= '0;
			sum_q        <= '0;
			max_q        <= '0;
			low_bin_q    <= '0;
			high_bin_q   <= '0;
		end else if (cmd.clear) begin
			count_q      <= '0;
			note_count_q <= '0;
			sum_q        <= '0;
			max_q        <= '0;
			low_bin_q    <= '0;
			high_bin_q   <= '0;
		end else if (cmd.update) begin
			count_q <= sat_inc(count_q);
			if (cmd.note)
				note_count_q <= sat_inc(note_count_q);
			// carry out of the sum pins it at all ones
			sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			if (cmd.elapsed > max_q)
				max_q <= cmd.elapsed;
			if (cmd.elapsed >= low_threshold)
				low_bin_q <= sat_inc(low_bin_q);
			if (cmd.elapsed >= high_threshold)
				high_bin_q <= sat_inc(high_bin_q);
		end
	end

	assign stats.count      = count_q;
	assign stats.note_count = note_count_q;
	assign stats.sum        = sum_q;
	assign stats.maximum    = max_q;
	assign stats.low_bin    = low_bin_q;
	assign stats.high_bin   = high_bin_q;

endmodule

`default_nettype wire

// ----- rtl/core/latency_window_statistics_core.sv -----
// ----------------------------------------------------------------------------
// latency_window_statistics_core
// Windowed latency monitor with an iterative divider for reports.
// ----------------------------------------------------------------------------
// One transaction at a time. A record or flush that produces no report goes
// through the check, update and decide steps before in_ready returns. A report
// adds one pass through the bit-serial divider for sum / count, the 16-bit
// digits of the sum, top digit first, through a reciprocal multiply for
// sum / 1000, and the load of the output register. The output register holds
// a report until it is taken, so the next transaction may be accepted
// meanwhile; a further report waits for that slot.
// No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module latency_window_statistics_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [lws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lws_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          mode,
	input  wire logic [lws_pkg::TIME_W-1:0]    now_time,
	input  wire logic [lws_pkg::TIME_W-1:0]    rx_time,
	input  wire logic                          note_on_flag,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [lws_pkg::CNT_W-1:0]     sample_count,
	output logic      [lws_pkg::CNT_W-1:0]     note_on_count,
	output logic      [lws_pkg::CNT_W-1:0]     average_us,
	output logic      [lws_pkg::CNT_W-1:0]     maximum_us,
	output logic      [lws_pkg::CNT_W-1:0]     sum_ms,
	output logic      [lws_pkg::CNT_W-1:0]     over_low_count,
	output logic      [lws_pkg::CNT_W-1:0]     over_high_count
);
	import lws_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CHECK   = 3'd1;
	localparam logic [2:0] S_UPDATE  = 3'd2;
	localparam logic [2:0] S_DECIDE  = 3'd3;
	localparam logic [2:0] S_DIV_AVG = 3'd4;
	localparam logic [2:0] S_DIV_MS  = 3'd5;
	localparam logic [2:0] S_EMIT    = 3'd6;

	logic [2:0]        state_q;

	logic [CFG_W-1:0]  window_q;
	logic [CFG_W-1:0]  min_interval_q;
	logic [CFG_W-1:0]  low_thresh_q;
	logic [CFG_W-1:0]  high_thresh_q;

	logic              mode_q;
	logic              note_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] rx_q;
	logic [TIME_W-1:0] last_report_q;
	logic              interval_ok_q;
	logic              sample_ok_q;
	logic [CNT_W-1:0]  elapsed_q;
	logic [CNT_W-1:0]  avg_q;

	logic [MS_DIGIT_IDX_W-1:0] ms_digit_q;
	logic [MS_REM_W-1:0]       ms_rem_q;
	logic [CNT_W-1:0]          ms_quot_q;

	logic              out_valid_q;
	lws_stats_t        out_q;
	logic [CNT_W-1:0]  out_avg_q;
	logic [CNT_W-1:0]  out_ms_q;

	logic              in_fire;
	logic              report;
	logic              out_load;
	logic              div_start;
	logic [DIV_DSR_W-1:0] div_divisor;
	logic [DIV_DVD_W-1:0] div_quotient;
	lws_div_status_t   div_status;
	lws_stat_cmd_t     stat_cmd;
	lws_stats_t        stats;
	logic [TIME_W-1:0] since_report;
	logic [TIME_W-1:0] age;

	logic [MS_PART_W-1:0]  ms_part;
	logic [MS_PROD_W-1:0]  ms_prod;
	logic [MS_DIGIT_W-1:0] ms_qd;
	logic [MS_REM_W-1:0]   ms_back;
	logic [MS_REM_W-1:0]   ms_rem_next;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign since_report = now_q - last_report_q;
	assign age          = now_q - rx_q;

	// Flush reports on interval and a nonempty window; a record also needs a valid sample and a full window
	assign report = (stats.count != '0) && interval_ok_q &&
		(mode_q || (sample_ok_q && (stats.count >= window_q)));

	assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	assign div_start   = (state_q == S_DECIDE) && report;
	assign div_divisor = stats.count;

	// One digit of sum / 1000 per cycle; the remainder is below 1000, so its
	// low bits are enough to form it
	assign ms_part     = {ms_rem_q, stats.sum[ms_digit_q * MS_DIGIT_W +: MS_DIGIT_W]};
	assign ms_prod     = MS_PROD_W'(ms_part) * MS_PROD_W'(MS_RECIP);
	assign ms_qd       = ms_prod[MS_RECIP_SHIFT +: MS_DIGIT_W];
	assign ms_back     = MS_REM_W'(ms_qd) * MS_REM_W'(MS_DIVISOR);
	assign ms_rem_next = ms_part[MS_REM_W-1:0] - ms_back;

	assign stat_cmd.update  = (state_q == S_UPDATE) && !mode_q && sample_ok_q;
	assign stat_cmd.clear   = out_load;
	assign stat_cmd.note    = note_q;
	assign stat_cmd.elapsed = elapsed_q;

	lws_stats u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (stat_cmd),
		.low_threshold  (low_thresh_q),
		.high_threshold (high_thresh_q),
		.stats          (stats)
	);

	lws_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (stats.sum),
		.divisor  (div_divisor),
		.status   (div_status),
		.quotient (div_quotient)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q       <= WINDOW_COUNT_RST;
			min_interval_q <= MIN_INTERVAL_RST;
			low_thresh_q   <= LOW_THRESH_RST;
			high_thresh_q  <= HIGH_THRESH_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW_COUNT: window_q       <= cfg_data;
				REG_MIN_INTERVAL: min_interval_q <= cfg_data;
				REG_LOW_THRESH:   low_thresh_q   <= cfg_data;
				REG_HIGH_THRESH:  high_thresh_q  <= cfg_data;
				default:          window_q       <= window_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			last_report_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire)
						state_q <= S_CHECK;
				end
				S_CHECK:  state_q <= S_UPDATE;
				S_UPDATE: state_q <= S_DECIDE;
				S_DECIDE: begin
					state_q <= report ? S_DIV_AVG : S_IDLE;
				end
				S_DIV_AVG: begin
					if (div_status.done)
						state_q <= S_DIV_MS;
				end
				S_DIV_MS: begin
					if (ms_digit_q == '0)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load) begin
						state_q       <= S_IDLE;
						last_report_q <= now_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Transaction capture and per-item checks
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= mode;
			note_q <= note_on_flag;
			now_q  <= now_time;
			rx_q   <= rx_time;
		end
		if (state_q == S_CHECK) begin
			interval_ok_q <= since_report >= {(TIME_W - CFG_W)'(0), min_interval_q};
			sample_ok_q   <= (rx_q != '0) && (now_q >= rx_q);
			elapsed_q     <= age[CNT_W-1:0];
		end
		if ((state_q == S_DIV_AVG) && div_status.done) begin
			avg_q      <= div_quotient[CNT_W-1:0];
			ms_digit_q <= '1;
			ms_rem_q   <= '0;
		end
		// only the two lowest quotient digits stay in the register
		if (state_q == S_DIV_MS) begin
			ms_digit_q <= ms_digit_q - 1'b1;
			ms_rem_q   <= ms_rem_next;
			ms_quot_q  <= {ms_quot_q[CNT_W-MS_DIGIT_W-1:0], ms_qd};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q     <= stats;
			out_avg_q <= avg_q;
			out_ms_q  <= ms_quot_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign sample_count    = out_q.count;
	assign note_on_count   = out_q.note_count;
	assign average_us      = out_avg_q;
	assign maximum_us      = out_q.maximum;
	assign sum_ms          = out_ms_q;
	assign over_low_count  = out_q.low_bin;
	assign over_high_count = out_q.high_bin;

	// Checks
	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("report appeared outside the emit step");

	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_status.busy)
		else $error("divider restarted while busy");

	a_clear_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (stats.count == '0) && (stats.sum == '0))
		else $error("statistics not cleared after report");

	a_report_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.count != '0))
		else $error("report with empty window");

endmodule

`default_nettype wire
